// ===== rtl/lpc_pkg.sv =====
package lpc_pkg;

   localparam int LABEL_BITS_DEFAULT = 8;

   localparam int BASE_WIDTH    = 8;
   localparam int OVERLAY_WIDTH = 8;
   localparam int MERGED_WIDTH  = 8;
   localparam int USED_WIDTH    = 9;

   localparam int REQ_DATA_WIDTH = 16;
   localparam int RSP_DATA_WIDTH = 24;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_CHECK
   } lpc_state_type;

endpackage

// ===== rtl/label_pair_compaction_core.sv =====
// Label pair compaction core.
// Each request transaction carries a base label and an overlay label in
// req_tdata and a start-of-pass flag in req_tuser. Each distinct label pair
// receives a dense label in first-seen order, and the pair (0,0) maps to 0.
// Each request produces exactly one response transaction with the merged label
// and the label count in rsp_tdata and an overflow flag in rsp_tuser.
// A request steps through the states IDLE, LOOKUP and CHECK: the pair table is
// read at the pair key, then a reverse table is read at the stored label, then
// the entry is checked and, for a new pair, written. The two dependent memory
// reads set this sequence, so the block takes no new request until CHECK ends.
// An entry counts as valid only if its label is below the next free label and
// the reverse table points back at the same pair, so a new pass needs no
// clearing sweep and the block is ready in the first cycle after reset.
// Reset empties the response register and restarts numbering at 1.
// When the receiver stalls, the finished response holds in its register and
// the core waits in its final step until the response is taken.
module label_pair_compaction_core #(
   parameter int LABEL_BITS = lpc_pkg::LABEL_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // Bits from low: base_label[7:0], overlay_label[15:8].
   input  logic [lpc_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   // Bits from low: start_pass[0].
   input  logic [0:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Bits from low: merged_label[7:0], labels_used[16:8], zero padding[23:17].
   output logic [lpc_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // Bits from low: label_overflow[0].
   output logic [0:0]                         rsp_tuser
);

   import lpc_pkg::*;

   localparam int KEY_BITS   = 2 * LABEL_BITS;
   localparam int PAIR_COUNT = 1 << KEY_BITS;
   localparam int LABEL_COUNT = 1 << LABEL_BITS;
   localparam int COUNT_BITS = LABEL_BITS + 1;

   lpc_state_type state_ff, state_in;

   logic                  start_ff, start_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [COUNT_BITS-1:0] next_free_ff, next_free_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [MERGED_WIDTH-1:0] merged_ff, merged_in;
   logic [USED_WIDTH-1:0]   used_ff, used_in;
   logic                    overflow_ff, overflow_in;

   logic [KEY_BITS-1:0]   req_key;
   logic                  table_rd_en;
   logic [LABEL_BITS-1:0] table_rd_data;
   logic                  rev_rd_en;
   logic [KEY_BITS-1:0]   rev_rd_data;
   logic                  assign_en;

   logic [COUNT_BITS-1:0] free_eff;
   logic                  entry_hit;
   logic                  commit;

   assign req_key = {req_tdata[BASE_WIDTH +: LABEL_BITS], req_tdata[0 +: LABEL_BITS]};
   assign req_tready = (state_ff == ST_IDLE);

   assign free_eff  = start_ff ? COUNT_BITS'(1) : next_free_ff;
   assign entry_hit = (table_rd_data != '0) &&
                      ({1'b0, table_rd_data} < free_eff) &&
                      (rev_rd_data == key_ff);
   assign commit    = (state_ff == ST_CHECK) && (!rsp_valid_ff || rsp_tready);

   lpc_ram #(
      .WIDTH(LABEL_BITS),
      .DEPTH(PAIR_COUNT)
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (assign_en),
      .wr_addr (key_ff),
      .wr_data (free_eff[LABEL_BITS-1:0]),
      .rd_en   (table_rd_en),
      .rd_addr (req_key),
      .rd_data (table_rd_data)
   );

   lpc_ram #(
      .WIDTH(KEY_BITS),
      .DEPTH(LABEL_COUNT)
   ) u_rev_ram (
      .clock   (clock),
      .wr_en   (assign_en),
      .wr_addr (free_eff[LABEL_BITS-1:0]),
      .wr_data (key_ff),
      .rd_en   (rev_rd_en),
      .rd_addr (table_rd_data),
      .rd_data (rev_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         next_free_ff <= COUNT_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_free_ff <= next_free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      start_ff    <= start_in;
      key_ff      <= key_in;
      merged_ff   <= merged_in;
      used_ff     <= used_in;
      overflow_ff <= overflow_in;
   end

   always_comb begin
      state_in     = state_ff;
      start_in     = start_ff;
      key_in       = key_ff;
      next_free_in = next_free_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      merged_in    = merged_ff;
      used_in      = used_ff;
      overflow_in  = overflow_ff;
      table_rd_en  = 1'b0;
      rev_rd_en    = 1'b0;
      assign_en    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               table_rd_en = 1'b1;
               start_in    = req_tuser[0];
               key_in      = req_key;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            rev_rd_en = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            if (commit) begin
               next_free_in = free_eff;
               merged_in    = '0;
               overflow_in  = 1'b0;
               if (key_ff != '0) begin
                  if (entry_hit) begin
                     merged_in = MERGED_WIDTH'(table_rd_data);
                  end else if (!free_eff[LABEL_BITS]) begin
                     assign_en    = 1'b1;
                     merged_in    = MERGED_WIDTH'(free_eff[LABEL_BITS-1:0]);
                     next_free_in = free_eff + COUNT_BITS'(1);
                  end else begin
                     overflow_in = 1'b1;
                  end
               end
               used_in      = USED_WIDTH'(next_free_in);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {{(RSP_DATA_WIDTH - USED_WIDTH - MERGED_WIDTH){1'b0}},
                          used_ff, merged_ff};
   assign rsp_tuser[0] = overflow_ff;

   a_accept_walk: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_LOOKUP) ##1 (state_ff == ST_CHECK))
      else $error("request did not step through lookup and check");

   a_assign_count: assert property (@(posedge clock) disable iff (reset)
      assign_en |=> (next_free_ff == $past(free_eff) + COUNT_BITS'(1)))
      else $error("label assignment did not advance the free label");

   a_overflow_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && overflow_ff) |-> (merged_ff == '0))
      else $error("overflow response carries a nonzero label");

   a_write_free: assert property (@(posedge clock) disable iff (reset)
      assign_en |-> (!free_eff[LABEL_BITS] && (key_ff != '0) && !entry_hit))
      else $error("table written for a known, empty or exhausted pair");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> rsp_valid_ff && $stable(merged_ff))
      else $error("stalled response was overwritten");

endmodule

// ===== rtl/lpc_ram.sv =====
module lpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sim/label_pair_compaction_core_tb.sv =====
module label_pair_compaction_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lpc_pkg::*;

   localparam int LABEL_BITS       = LABEL_BITS_DEFAULT;
   localparam int MAX_LABEL        = (1 << LABEL_BITS) - 1;
   localparam int RANDOM_VOXELS    = 500;
   localparam int LONG_STALL       = 300;
   localparam int DRAIN_CYCLES     = 20;
   localparam int WATCHDOG_LIMIT   = 5000;

   typedef struct packed {
      logic [MERGED_WIDTH-1:0] merged_label;
      logic                    label_overflow;
      logic [USED_WIDTH-1:0]   labels_used;
   } merged_voxel_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata;
   logic [0:0]                req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic [0:0]                rsp_tuser;

   merged_voxel_type         pending_labels[$];
   logic [MERGED_WIDTH-1:0]  pair_labels[logic [2*LABEL_BITS-1:0]];
   logic [USED_WIDTH-1:0]    free_label;
   int                       error_count;
   int                       voxels_sent;
   int                       idle_cycles;
   int                       stall_requests;
   bit                       send_burst;

   label_pair_compaction_core #(
      .LABEL_BITS(LABEL_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic merged_voxel_type merge_pair(bit start, logic [7:0] base_label,
                                                   logic [7:0] overlay_label);
      merged_voxel_type         result;
      logic [2*LABEL_BITS-1:0]  pair_key;
      if (start) begin
         pair_labels.delete();
         free_label = USED_WIDTH'(1);
      end
      pair_key = {base_label[LABEL_BITS-1:0], overlay_label[LABEL_BITS-1:0]};
      result.merged_label   = '0;
      result.label_overflow = 1'b0;
      if (pair_key != '0) begin
         if (pair_labels.exists(pair_key)) begin
            result.merged_label = pair_labels[pair_key];
         end else if (free_label <= MAX_LABEL) begin
            result.merged_label = free_label[MERGED_WIDTH-1:0];
            pair_labels[pair_key] = free_label[MERGED_WIDTH-1:0];
            free_label++;
         end else begin
            result.label_overflow = 1'b1;
         end
      end
      result.labels_used = free_label;
      return result;
   endfunction

   task automatic send_voxel(input bit start, input logic [7:0] base_label,
                             input logic [7:0] overlay_label);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 10);
      if ($urandom_range(0, 31) == 0) begin
         send_burst = !send_burst;
      end
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {overlay_label, base_label};
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      pending_labels.push_back(merge_pair(start, base_label, overlay_label));
      voxels_sent++;
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic test_no_start_marker();
      send_voxel(1'b0, 8'd0, 8'd0);
      send_voxel(1'b0, 8'd1, 8'd0);
      send_voxel(1'b0, 8'd0, 8'd1);
      send_voxel(1'b0, 8'd1, 8'd0);
      stop_sending();
   endtask

   task automatic test_field_extremes();
      send_voxel(1'b1, 8'd255, 8'd255);
      send_voxel(1'b0, 8'd0, 8'd255);
      send_voxel(1'b0, 8'd255, 8'd0);
      send_voxel(1'b0, 8'd0, 8'd0);
      send_voxel(1'b0, 8'd255, 8'd255);
      send_voxel(1'b0, 8'd128, 8'd1);
      send_voxel(1'b1, 8'd0, 8'd0);
      send_voxel(1'b0, 8'd255, 8'd255);
      stop_sending();
   endtask

   task automatic test_repeated_pairs();
      send_voxel(1'b1, 8'd2, 8'd3);
      send_voxel(1'b0, 8'd3, 8'd2);
      send_voxel(1'b0, 8'd2, 8'd3);
      send_voxel(1'b0, 8'd0, 8'd0);
      send_voxel(1'b0, 8'd3, 8'd2);
      send_voxel(1'b0, 8'd2, 8'd2);
      send_voxel(1'b1, 8'd3, 8'd2);
      send_voxel(1'b0, 8'd2, 8'd3);
      stop_sending();
   endtask

   task automatic test_label_exhaustion();
      logic [7:0] step;
      send_voxel(1'b1, 8'd1, 8'd7);
      for (int i = 2; i <= MAX_LABEL; i++) begin
         step = 8'(i);
         send_voxel(1'b0, step, 8'(i * 7));
      end
      send_voxel(1'b0, 8'd0, 8'd1);
      send_voxel(1'b0, 8'd0, 8'd1);
      send_voxel(1'b0, 8'd5, 8'd35);
      send_voxel(1'b0, 8'd0, 8'd0);
      send_voxel(1'b0, 8'd255, 8'd255);
      send_voxel(1'b1, 8'd0, 8'd1);
      stop_sending();
   endtask

   task automatic test_receiver_stall();
      stall_requests++;
      send_burst = 1'b1;
      send_voxel(1'b1, 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)));
      repeat (30) begin
         send_voxel(1'b0, 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)));
      end
      stop_sending();
   endtask

   task automatic test_random_passes();
      int         first_voxel;
      int         pass_length;
      int         label_range;
      bit         start;
      first_voxel = voxels_sent;
      while (voxels_sent - first_voxel < RANDOM_VOXELS) begin
         if ($urandom_range(0, 5) == 0) begin
            pass_length = $urandom_range(260, 280);
            label_range = 255;
         end else begin
            pass_length = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
               0: label_range = 1;
               1: label_range = 3;
               2: label_range = 15;
               default: label_range = 255;
            endcase
         end
         for (int i = 0; i < pass_length; i++) begin
            if (i == 0) begin
               start = ($urandom_range(0, 7) != 0);
            end else begin
               start = ($urandom_range(0, 31) == 0);
            end
            send_voxel(start, 8'($urandom_range(0, label_range)),
                       8'($urandom_range(0, label_range)));
         end
      end
      stop_sending();
   endtask

   initial begin : response_sink
      int hold;
      int pause;
      int stalls_served;
      bit rsp_taken;
      bit take_burst;
      rsp_tready = 1'b0;
      hold = 0;
      pause = 0;
      stalls_served = 0;
      take_burst = 1'b0;
      forever begin
         @(posedge clock);
         rsp_taken = !reset && rsp_tvalid && rsp_tready;
         @(negedge clock);
         if (stall_requests != stalls_served) begin
            stalls_served = stall_requests;
            hold = LONG_STALL;
         end
         if (rsp_taken) begin
            pause = take_burst ? 0 : $urandom_range(0, 10);
            if ($urandom_range(0, 31) == 0) begin
               take_burst = !take_burst;
            end
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (pause > 0) begin
            pause--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      merged_voxel_type expected;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_labels.size() == 0) begin
            $error("Response transaction arrived with no expected result pending.");
            error_count++;
         end else begin
            expected = pending_labels.pop_front();
            if (rsp_tdata[7:0] !== expected.merged_label) begin
               $error("merged_label: expected %0d, actual %0d",
                      expected.merged_label, rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tdata[16:8] !== expected.labels_used) begin
               $error("labels_used: expected %0d, actual %0d",
                      expected.labels_used, rsp_tdata[16:8]);
               error_count++;
            end
            if (rsp_tuser[0] !== expected.label_overflow) begin
               $error("label_overflow: expected %0d, actual %0d",
                      expected.label_overflow, rsp_tuser[0]);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      voxels_sent   = 0;
      send_burst    = 1'b0;
      free_label    = USED_WIDTH'(1);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_no_start_marker();
      test_field_extremes();
      test_repeated_pairs();
      test_label_exhaustion();
      test_receiver_stall();
      test_random_passes();

      while (pending_labels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/lpc_pkg.sv
rtl/lpc_ram.sv
rtl/label_pair_compaction_core.sv
sim/label_pair_compaction_core_tb.sv
